[src/dcsr_pkg.sv]
package dcsr_pkg;

  localparam int MAX_ROWS     = 64;
  localparam int MAX_COLS     = 64;
  localparam int MAX_NONZEROS = 4096;
  localparam int VALUE_BITS   = 32;

  localparam int SIZE_BITS    = 7;
  localparam int COUNT_BITS   = 13;
  localparam int QUERY_BITS   = 8;
  localparam int COL_IDX_BITS = 6;
  localparam int ROW_IDX_BITS = $clog2(MAX_ROWS);
  localparam int NZ_IDX_BITS  = $clog2(MAX_NONZEROS);

  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } op_kind_t;

  typedef enum logic {
    RES_LOAD   = 1'b0,
    RES_LOOKUP = 1'b1
  } res_kind_t;

  typedef enum logic {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROWS,
    ST_WALK,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    op_kind_t                      kind;
    logic signed [VALUE_BITS-1:0]  value;
    logic                          first;
    logic                          last;
    logic [QUERY_BITS-1:0]         qrow;
    logic [QUERY_BITS-1:0]         qcol;
  } op_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] row_count;
    logic [SIZE_BITS-1:0] column_count;
  } cfg_regs_t;

  typedef struct packed {
    logic [COL_IDX_BITS-1:0]       col;
    logic signed [VALUE_BITS-1:0]  value;
  } entry_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] rows;
    logic [SIZE_BITS-1:0] cols;
  } sizes_t;

  function automatic sizes_t eff_sizes(cfg_regs_t c);
    sizes_t s;
    s.rows = (c.row_count > SIZE_BITS'(MAX_ROWS)) ? SIZE_BITS'(MAX_ROWS) : c.row_count;
    s.cols = (c.column_count > SIZE_BITS'(MAX_COLS)) ? SIZE_BITS'(MAX_COLS) : c.column_count;
    if (s.rows == '0 || s.cols == '0) begin
      s.rows = '0;
      s.cols = '0;
    end
    return s;
  endfunction

endpackage

[src/dcsr_if.sv]
interface dcsr_item_if import dcsr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [VALUE_BITS-1:0] element_value;
  logic                         first_element;
  logic                         last_element;
  logic [QUERY_BITS-1:0]        query_row;
  logic [QUERY_BITS-1:0]        query_col;

  modport source (output valid, command, element_value, first_element, last_element,
                  query_row, query_col, input ready);
  modport sink (input valid, command, element_value, first_element, last_element,
                query_row, query_col, output ready);
endinterface

interface dcsr_result_if import dcsr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         result_kind;
  logic signed [VALUE_BITS-1:0] read_value;
  logic                         range_error;
  logic [COUNT_BITS-1:0]        nonzero_total;

  modport source (output valid, result_kind, read_value, range_error, nonzero_total,
                  input ready);
  modport sink (input valid, result_kind, read_value, range_error, nonzero_total,
                output ready);
endinterface

interface dcsr_cfg_if import dcsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 index;
  logic [SIZE_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/dense_to_csr_compress_lookup.sv]
// A load passes the front holding register and the queue before it reaches the back end,
// where a last_element load registers its report. A lookup in range walks the back-end states
// ROWS, WALK and EMIT, scanning the stored row entries one per cycle up to the match.
// Throughput: one load per cycle unless a lookup or the result output stalls the back end.
// Reset clears the queue, row bookkeeping, counters and both size registers to zero;
// entry storage is not cleared and no clearing pass runs.
module dense_to_csr_compress_lookup import dcsr_pkg::*; (
  input logic          clk,
  input logic          rst,
  dcsr_item_if.sink    item,
  dcsr_result_if.source result,
  dcsr_cfg_if.sink     cfg
);

  cfg_regs_t cfg_regs;
  logic      push_valid, push_ready, pop_valid, pop_ready;
  op_t       push_op, pop_op;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (reg_index_t'(cfg.index))
        REG_ROW_COUNT:    cfg_regs.row_count <= cfg.data;
        REG_COLUMN_COUNT: cfg_regs.column_count <= cfg.data;
        default: ;
      endcase
    end
  end

  dcsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_ready (push_ready)
  );

  dcsr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_op     (pop_op),
    .pop_ready  (pop_ready)
  );

  dcsr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .q_valid  (pop_valid),
    .q_op     (pop_op),
    .q_ready  (pop_ready),
    .result   (result)
  );

endmodule

[src/dcsr_front.sv]
module dcsr_front import dcsr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  dcsr_item_if.sink    item,
  output logic         push_valid,
  output op_t          push_op,
  input  logic         push_ready
);

  logic held;
  op_t  held_op;

  assign item.ready = !held || push_ready;
  assign push_valid = held;
  assign push_op    = held_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item.ready) begin
      held <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      held_op.kind  <= op_kind_t'(item.command);
      held_op.value <= item.element_value;
      held_op.first <= item.first_element;
      held_op.last  <= item.last_element;
      held_op.qrow  <= item.query_row;
      held_op.qcol  <= item.query_col;
    end
  end

endmodule

[src/dcsr_queue.sv]
module dcsr_queue import dcsr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  op_t  push_op,
  output logic push_ready,
  output logic pop_valid,
  output op_t  pop_op,
  input  logic pop_ready
);

  op_t                  slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] fill;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = fill != QCNT_BITS'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_op     = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

[src/dcsr_back.sv]
module dcsr_back import dcsr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_regs_t     cfg_regs,
  input  logic          q_valid,
  input  op_t           q_op,
  output logic          q_ready,
  dcsr_result_if.source result
);

  back_state_t state, state_next;

  logic [SIZE_BITS-1:0]    load_row;
  logic [SIZE_BITS-1:0]    load_col;
  logic [COUNT_BITS-1:0]   cnt;
  logic                    loaded;
  logic [MAX_ROWS-1:0]     row_valid;
  logic                    fill_on;
  logic [SIZE_BITS-1:0]    fill_lo;
  logic [SIZE_BITS-1:0]    fill_hi;
  logic [COUNT_BITS-1:0]   fill_val;

  logic [COUNT_BITS-1:0]   row_end [MAX_ROWS];
  logic [COUNT_BITS-1:0]   rd_a;
  logic [COUNT_BITS-1:0]   rd_b;
  logic                    a_zero, a_fill, a_valid, b_fill, b_valid;

  entry_t                  entries [MAX_NONZEROS];
  entry_t                  ent_q;
  logic [COL_IDX_BITS-1:0] qcol_r;
  logic [COUNT_BITS-1:0]   walk_idx;
  logic [COUNT_BITS-1:0]   walk_end;
  logic                    rd_pend;
  logic signed [VALUE_BITS-1:0] res_value;

  logic                    out_valid;
  logic                    out_kind;
  logic signed [VALUE_BITS-1:0] out_value;
  logic                    out_err;
  logic [COUNT_BITS-1:0]   out_total;

  sizes_t                  sz;
  logic                    out_free;
  logic                    lk_err;

  logic [SIZE_BITS-1:0]    lr0, lc0, r1, c1, c2, r2, c2f, lr_s, lc_s;
  logic [COUNT_BITS-1:0]   cnt0, cnt1;
  logic                    ld0, active, doit, store;

  logic [ROW_IDX_BITS-1:0] ra, rb;
  logic [COUNT_BITS-1:0]   walk_start, walk_stop;

  logic ld_exec, lk_err_emit, lk_start, rows_load, walk_issue, walk_hit, walk_miss, emit_res;

  assign sz       = eff_sizes(cfg_regs);
  assign out_free = !out_valid || result.ready;
  assign lk_err   = (q_op.qrow >= QUERY_BITS'(sz.rows)) || (q_op.qcol >= QUERY_BITS'(sz.cols));

  assign result.valid         = out_valid;
  assign result.result_kind   = out_kind;
  assign result.read_value    = out_value;
  assign result.range_error   = out_err;
  assign result.nonzero_total = out_total;

  always_comb begin
    lr0    = q_op.first ? '0 : load_row;
    lc0    = q_op.first ? '0 : load_col;
    cnt0   = q_op.first ? '0 : cnt;
    ld0    = q_op.first ? 1'b0 : loaded;
    active = !ld0 && (lr0 < sz.rows);
    r1     = (lc0 >= sz.cols) ? lr0 + SIZE_BITS'(1) : lr0;
    c1     = (lc0 >= sz.cols) ? '0 : lc0;
    doit   = active && (r1 < sz.rows);
    store  = doit && (q_op.value != '0) && (cnt0 < COUNT_BITS'(MAX_NONZEROS));
    cnt1   = cnt0 + COUNT_BITS'(store);
    c2     = c1 + SIZE_BITS'(1);
    r2     = (c2 >= sz.cols) ? r1 + SIZE_BITS'(1) : r1;
    c2f    = (c2 >= sz.cols) ? '0 : c2;
    if (doit) begin
      lr_s = r2;
      lc_s = c2f;
    end else if (active) begin
      lr_s = r1;
      lc_s = c1;
    end else begin
      lr_s = lr0;
      lc_s = lc0;
    end
  end

  assign rb = q_op.qrow[ROW_IDX_BITS-1:0];
  assign ra = rb - ROW_IDX_BITS'(1);

  always_comb begin
    if (a_zero) begin
      walk_start = '0;
    end else if (a_fill) begin
      walk_start = fill_val;
    end else if (a_valid) begin
      walk_start = rd_a;
    end else begin
      walk_start = '0;
    end
    if (b_fill) begin
      walk_stop = fill_val;
    end else if (b_valid) begin
      walk_stop = rd_b;
    end else begin
      walk_stop = '0;
    end
  end

  always_comb begin
    q_ready     = 1'b0;
    ld_exec     = 1'b0;
    lk_err_emit = 1'b0;
    lk_start    = 1'b0;
    rows_load   = 1'b0;
    walk_issue  = 1'b0;
    walk_hit    = 1'b0;
    walk_miss   = 1'b0;
    emit_res    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_op.kind == OP_LOAD) begin
            if (!q_op.last || out_free) begin
              q_ready = 1'b1;
              ld_exec = 1'b1;
            end
          end else if (lk_err) begin
            if (out_free) begin
              q_ready     = 1'b1;
              lk_err_emit = 1'b1;
            end
          end else begin
            q_ready  = 1'b1;
            lk_start = 1'b1;
          end
        end
      end
      ST_ROWS: rows_load = 1'b1;
      ST_WALK: begin
        if (rd_pend && ent_q.col == qcol_r) begin
          walk_hit = 1'b1;
        end else if (walk_idx < walk_end) begin
          walk_issue = 1'b1;
        end else begin
          walk_miss = 1'b1;
        end
      end
      ST_EMIT: emit_res = out_free;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (lk_start) state_next = ST_ROWS;
      ST_ROWS: state_next = ST_WALK;
      ST_WALK: if (walk_hit || walk_miss) state_next = ST_EMIT;
      ST_EMIT: if (emit_res) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      load_row  <= '0;
      load_col  <= '0;
      cnt       <= '0;
      loaded    <= 1'b0;
      row_valid <= '0;
      fill_on   <= 1'b0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (ld_exec) begin
        cnt      <= cnt1;
        load_row <= lr_s;
        load_col <= lc_s;
        loaded   <= ld0;
        if (q_op.first) begin
          row_valid <= '0;
          fill_on   <= 1'b0;
        end
        if (doit) begin
          row_valid[r1[ROW_IDX_BITS-1:0]] <= 1'b1;
        end
        if (q_op.last) begin
          out_valid <= 1'b1;
          if (!ld0) begin
            fill_on  <= 1'b1;
            load_row <= (lr_s < sz.rows) ? sz.rows : lr_s;
            load_col <= '0;
            loaded   <= 1'b1;
          end
        end
      end
      if (lk_err_emit || emit_res) begin
        out_valid <= 1'b1;
      end
      if (lk_start) begin
        rd_pend <= 1'b0;
      end
      if (walk_issue) begin
        rd_pend <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_exec && q_op.last) begin
      out_kind  <= RES_LOAD;
      out_value <= '0;
      out_err   <= 1'b0;
      out_total <= cnt1;
      if (!ld0) begin
        fill_lo  <= lr_s;
        fill_hi  <= sz.rows;
        fill_val <= cnt1;
      end
    end
    if (lk_err_emit) begin
      out_kind  <= RES_LOOKUP;
      out_value <= '0;
      out_err   <= 1'b1;
      out_total <= cnt;
    end
    if (emit_res) begin
      out_kind  <= RES_LOOKUP;
      out_value <= res_value;
      out_err   <= 1'b0;
      out_total <= cnt;
    end
    if (lk_start) begin
      qcol_r  <= q_op.qcol[COL_IDX_BITS-1:0];
      a_zero  <= rb == '0;
      a_fill  <= fill_on && (SIZE_BITS'(ra) >= fill_lo) && (SIZE_BITS'(ra) < fill_hi);
      a_valid <= row_valid[ra];
      b_fill  <= fill_on && (SIZE_BITS'(rb) >= fill_lo) && (SIZE_BITS'(rb) < fill_hi);
      b_valid <= row_valid[rb];
    end
    if (rows_load) begin
      walk_idx <= walk_start;
      walk_end <= walk_stop;
    end
    if (walk_issue) begin
      walk_idx <= walk_idx + COUNT_BITS'(1);
    end
    if (walk_hit) begin
      res_value <= ent_q.value;
    end
    if (walk_miss) begin
      res_value <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_exec && doit) begin
      row_end[r1[ROW_IDX_BITS-1:0]] <= cnt1;
    end
    if (lk_start) begin
      rd_a <= row_end[ra];
      rd_b <= row_end[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_exec && store) begin
      entries[cnt0[NZ_IDX_BITS-1:0]] <= '{col: c1[COL_IDX_BITS-1:0], value: q_op.value};
    end
    if (walk_issue) begin
      ent_q <= entries[walk_idx[NZ_IDX_BITS-1:0]];
    end
  end

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    walk_issue |-> walk_idx < walk_end)
    else $error("entry read past the end of the row");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    cnt <= COUNT_BITS'(MAX_NONZEROS))
    else $error("nonzero count beyond capacity");

  a_loaded_col: assert property (@(posedge clk) disable iff (rst)
    loaded |-> load_col == '0)
    else $error("completed matrix with open column position");

  a_fill_loaded: assert property (@(posedge clk) disable iff (rst)
    fill_on |-> loaded)
    else $error("row fill active on an incomplete matrix");

  a_rows_walk: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROWS |=> state == ST_WALK)
    else $error("row bounds not followed by walk");

endmodule

[bench/tb.sv]
module tb;
  import dcsr_pkg::*;

  typedef struct {
    res_kind_t                    kind;
    logic signed [VALUE_BITS-1:0] value;
    logic                         err;
    logic [COUNT_BITS-1:0]        total;
  } answer_t;

  logic clk;
  logic rst;

  dcsr_item_if   item_bus ();
  dcsr_result_if result_bus ();
  dcsr_cfg_if    cfg_bus ();

  dense_to_csr_compress_lookup u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // CSR image of the matrix
  logic [SIZE_BITS-1:0]         rows_reg = '0;
  logic [SIZE_BITS-1:0]         cols_reg = '0;
  logic signed [VALUE_BITS-1:0] entry_val [MAX_NONZEROS];
  logic [COL_IDX_BITS-1:0]      entry_col [MAX_NONZEROS];
  logic [COUNT_BITS-1:0]        row_start [MAX_ROWS+1] = '{default: '0};
  int                           nz_count = 0;
  int                           fill_row = 0;
  int                           fill_col = 0;
  bit                           matrix_done = 1'b0;

  op_t         item_q [$];
  answer_t     answer_q [$];
  op_t         on_wire;
  int unsigned send_gap_pct = 17;
  int unsigned recv_gap_pct = 61;
  int          items_queued = 0;
  int          items_taken = 0;
  int          fail_count = 0;
  int          lookups_seen = 0;
  int          reports_seen = 0;
  int          cfg_writes = 0;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    item_bus.valid = 1'b0;
    item_bus.command = 1'b0;
    item_bus.element_value = '0;
    item_bus.first_element = 1'b0;
    item_bus.last_element = 1'b0;
    item_bus.query_row = '0;
    item_bus.query_col = '0;
    result_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = 1'b0;
    cfg_bus.data = '0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("run exceeded its time limit");
    $display("== FAIL ==");
    $finish;
  end

  function automatic void active_dims(output int r, output int c);
    r = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    c = (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    if (r == 0 || c == 0) begin
      r = 0;
      c = 0;
    end
  endfunction

  function automatic void mark_row_start(int k, int v);
    if (k <= MAX_ROWS) row_start[k] = COUNT_BITS'(v);
  endfunction

  function automatic void csr_store_step(op_t it);
    int      rows, cols, k, lo, hi;
    bit      hit;
    answer_t a;
    active_dims(rows, cols);
    a.value = '0;
    a.err = 1'b0;
    if (it.kind == OP_LOOKUP) begin
      a.kind = RES_LOOKUP;
      if (it.qrow >= rows || it.qcol >= cols) begin
        a.err = 1'b1;
      end else begin
        lo = row_start[it.qrow];
        hi = row_start[int'(it.qrow) + 1];
        hit = 1'b0;
        for (k = lo; k < hi && k < MAX_NONZEROS; k++) begin
          if (!hit && entry_col[k] == it.qcol) begin
            a.value = entry_val[k];
            hit = 1'b1;
          end
        end
      end
      a.total = COUNT_BITS'(nz_count);
      answer_q.push_back(a);
      return;
    end
    if (it.first) begin
      foreach (row_start[j]) row_start[j] = '0;
      nz_count = 0;
      fill_row = 0;
      fill_col = 0;
      matrix_done = 1'b0;
    end
    if (!matrix_done && fill_row < rows) begin
      if (fill_col >= cols) begin
        fill_col = 0;
        fill_row++;
      end
      if (fill_row < rows) begin
        if (fill_col == 0) mark_row_start(fill_row, nz_count);
        if (it.value != 0 && nz_count < MAX_NONZEROS) begin
          entry_val[nz_count] = it.value;
          entry_col[nz_count] = COL_IDX_BITS'(fill_col);
          nz_count++;
        end
        mark_row_start(fill_row + 1, nz_count);
        fill_col++;
        if (fill_col >= cols) begin
          fill_col = 0;
          fill_row++;
        end
      end
    end
    if (!it.last) return;
    if (!matrix_done) begin
      if (fill_row < rows && fill_col == 0) mark_row_start(fill_row, nz_count);
      for (k = fill_row + 1; k <= rows && k <= MAX_ROWS; k++) row_start[k] = COUNT_BITS'(nz_count);
      if (fill_row < rows) fill_row = rows;
      fill_col = 0;
      matrix_done = 1'b1;
    end
    a.kind = RES_LOAD;
    a.total = COUNT_BITS'(nz_count);
    answer_q.push_back(a);
  endfunction

  function automatic void push_load(logic signed [VALUE_BITS-1:0] v, bit f, bit l);
    op_t it;
    it.kind = OP_LOAD;
    it.value = v;
    it.first = f;
    it.last = l;
    it.qrow = QUERY_BITS'($urandom_range(255));
    it.qcol = QUERY_BITS'($urandom_range(255));
    item_q.push_back(it);
    items_queued++;
  endfunction

  function automatic void push_lookup(int r, int c);
    op_t it;
    it.kind = OP_LOOKUP;
    it.value = $urandom;
    it.first = $urandom_range(1);
    it.last = $urandom_range(1);
    it.qrow = QUERY_BITS'(r);
    it.qcol = QUERY_BITS'(c);
    item_q.push_back(it);
    items_queued++;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return '0;
    if (r < 43) return 32'sh7FFF_FFFF;
    if (r < 46) return 32'sh8000_0000;
    if (r < 48) return -32'sd1;
    if (r < 50) return 32'sd1;
    return $urandom;
  endfunction

  function automatic logic [SIZE_BITS-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return SIZE_BITS'(MAX_ROWS);
    if (r < 13) return 7'd127;
    if (r < 16) return SIZE_BITS'($urandom_range(65, 126));
    if (r < 22) return SIZE_BITS'($urandom_range(9, 63));
    return SIZE_BITS'($urandom_range(1, 8));
  endfunction

  function automatic void push_random_lookup(int rows, int cols);
    int unsigned r;
    r = $urandom_range(99);
    if (rows == 0 || r < 10) push_lookup($urandom_range(255), $urandom_range(255));
    else if (r < 15) push_lookup(rows, $urandom_range(cols - 1));
    else if (r < 20) push_lookup($urandom_range(rows - 1), cols);
    else push_lookup($urandom_range(rows - 1), $urandom_range(cols - 1));
  endfunction

  function automatic void fill_phase(int budget);
    int  rows, cols, n, k, made;
    op_t it;
    active_dims(rows, cols);
    made = 0;
    if ($urandom_range(1) == 1) begin
      n = $urandom_range(1, 5);
      for (k = 0; k < n; k++) push_load(pick_value(), 1'b0, k == n - 1);
      made += n;
    end
    while (made < budget) begin
      k = $urandom_range(99);
      if (k < 70) begin
        n = rows * cols;
        if (n == 0) n = $urandom_range(1, 3);
        if (n > 32 || $urandom_range(3) == 0) n = $urandom_range(1, (n > 32) ? 32 : n);
        else if ($urandom_range(5) == 0) n = n + $urandom_range(1, 3);
        for (k = 0; k < n; k++) begin
          push_load(pick_value(), k == 0, k == n - 1);
          if ($urandom_range(9) == 0) begin
            push_random_lookup(rows, cols);
            made++;
          end
        end
        made += n;
        n = $urandom_range(2, 6);
        for (k = 0; k < n; k++) push_random_lookup(rows, cols);
        made += n;
      end else if (k < 85) begin
        it.kind = op_kind_t'($urandom_range(1));
        it.value = $urandom;
        it.first = $urandom_range(1);
        it.last = $urandom_range(1);
        it.qrow = QUERY_BITS'($urandom_range(255));
        it.qcol = QUERY_BITS'($urandom_range(255));
        item_q.push_back(it);
        items_queued++;
        made++;
      end else begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) push_load(pick_value(), (k == 0) && ($urandom_range(1) == 1), 1'b0);
        made += n;
      end
    end
    if ($urandom_range(2) == 0) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) push_load(pick_value(), 1'b0, 1'b0);
    end
  endfunction

  task automatic wait_idle();
    @(posedge clk);
    while (items_taken != items_queued || answer_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [SIZE_BITS-1:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    if (idx == REG_ROW_COUNT) rows_reg = val;
    else cols_reg = val;
    cfg_writes++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        csr_store_step(on_wire);
        items_taken++;
      end
      if (!item_bus.valid || item_bus.ready) begin
        if (item_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          on_wire = item_q.pop_front();
          item_bus.valid <= 1'b1;
          item_bus.command <= on_wire.kind;
          item_bus.element_value <= on_wire.value;
          item_bus.first_element <= on_wire.first;
          item_bus.last_element <= on_wire.last;
          item_bus.query_row <= on_wire.qrow;
          item_bus.query_col <= on_wire.qcol;
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (result_bus.result_kind == RES_LOOKUP) lookups_seen++;
        else reports_seen++;
        if (answer_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result at %0t: kind %0d value %0d err %0d total %0d",
                     $time, result_bus.result_kind, result_bus.read_value,
                     result_bus.range_error, result_bus.nonzero_total);
        end else begin
          want = answer_q.pop_front();
          if (result_bus.result_kind !== want.kind || result_bus.read_value !== want.value ||
              result_bus.range_error !== want.err ||
              result_bus.nonzero_total !== want.total) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch at %0t: expected kind %0d value %0d err %0d total %0d,",
                        " got kind %0d value %0d err %0d total %0d"},
                       $time, want.kind, want.value, want.err, want.total,
                       result_bus.result_kind, result_bus.read_value,
                       result_bus.range_error, result_bus.nonzero_total);
          end
        end
      end
      result_bus.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  initial begin
    int          m, p;
    int unsigned send_mode [3];
    int unsigned recv_mode [3];
    send_mode = '{17, 61, 0};
    recv_mode = '{61, 17, 0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    push_lookup(0, 0);
    wait_idle();
    write_reg(REG_ROW_COUNT, 7'd2);
    write_reg(REG_COLUMN_COUNT, 7'd3);
    push_load(32'sh7FFF_FFFF, 1'b0, 1'b0);
    push_load(32'sd0, 1'b0, 1'b0);
    push_load(32'sh8000_0000, 1'b0, 1'b0);
    push_load(-32'sd1, 1'b0, 1'b0);
    push_load(32'sd0, 1'b0, 1'b0);
    push_load(32'sd1, 1'b0, 1'b1);
    push_lookup(0, 0);
    push_lookup(0, 1);
    push_lookup(0, 2);
    push_lookup(1, 0);
    push_lookup(1, 2);
    push_lookup(2, 0);
    push_lookup(0, 3);
    push_lookup(255, 255);
    push_load(32'sd9, 1'b0, 1'b1);
    push_load(32'sd5, 1'b1, 1'b0);
    push_lookup(0, 0);
    push_lookup(1, 1);
    push_load(32'sd0, 1'b0, 1'b1);
    wait_idle();
    write_reg(REG_ROW_COUNT, 7'd127);
    write_reg(REG_COLUMN_COUNT, 7'd64);
    push_load(-32'sd1, 1'b1, 1'b1);
    push_lookup(63, 63);
    push_lookup(64, 0);
    push_lookup(0, 0);
    wait_idle();
    write_reg(REG_ROW_COUNT, 7'd5);
    write_reg(REG_COLUMN_COUNT, 7'd0);
    push_load(32'sd3, 1'b1, 1'b1);
    push_lookup(0, 0);
    wait_idle();

    for (m = 0; m < 3; m++) begin
      send_gap_pct = send_mode[m];
      recv_gap_pct = recv_mode[m];
      for (p = 0; p < 5; p++) begin
        write_reg(REG_ROW_COUNT, pick_size());
        write_reg(REG_COLUMN_COUNT, pick_size());
        fill_phase(15);
        wait_idle();
      end
    end

    $display("covered %0d items: %0d lookup answers, %0d load reports, %0d register writes",
             items_taken, lookups_seen, reports_seen, cfg_writes);
    $display("with sender/receiver stalls swapped and then removed; %0d mismatches",
             fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
